// ===== hw/rtl/br1_pkg.sv =====
package br1_pkg;

    // Fixed number of byte lanes on the result channel
    localparam int NUM_LANES = 4;

    // Header that does nothing
    localparam logic [7:0] HDR_NOP = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       data_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] byte_count;
        logic       row_end;
        logic       error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_HDR,
        ST_LIT,
        ST_RUNB,
        ST_EMIT,
        ST_DISC
    } ctrl_state_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_LIT,
        EMIT_CHUNK,
        EMIT_ERR
    } emit_op_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_HDR,
        UPD_LIT,
        UPD_RUN,
        UPD_CLEAR_PKT,
        UPD_RESTART
    } upd_op_t;

    typedef struct packed {
        emit_op_t emit;
        upd_op_t  upd;
    } dp_cmd_t;

    typedef struct packed {
        logic is_lit_hdr;
        logic is_nop;
        logic hdr_fits;
        logic row_at_start;
        logic pkt_ok;
        logic pkt_one;
        logic lit_last_ok;
        logic run_exact;
        logic chunk_last;
        logic slot_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/br1_ctrl.sv =====
module br1_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               data_end,
    input  logic               cfg_fire,
    input  br1_pkg::dp_status_t status,
    output logic               item_ready,
    output br1_pkg::dp_cmd_t    cmd
);

    br1_pkg::ctrl_state_t state_reg;
    br1_pkg::ctrl_state_t state_next;
    logic                 item_fire;

    assign item_ready = (state_reg != br1_pkg::ST_EMIT) && status.slot_free;
    assign item_fire  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= br1_pkg::ST_HDR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        logic fail;
        fail       = 1'b0;
        state_next = state_reg;
        cmd.emit   = br1_pkg::EMIT_NONE;
        cmd.upd    = br1_pkg::UPD_NONE;

        unique case (state_reg)
            br1_pkg::ST_HDR:
            begin
                if (item_fire)
                begin
                    if (status.is_nop)
                        fail = data_end && !status.row_at_start;
                    else if (!status.hdr_fits || data_end)
                        fail = 1'b1;
                    else
                    begin
                        cmd.upd    = br1_pkg::UPD_HDR;
                        state_next = status.is_lit_hdr ? br1_pkg::ST_LIT : br1_pkg::ST_RUNB;
                    end
                end
            end
            br1_pkg::ST_LIT:
            begin
                if (item_fire)
                begin
                    if (!status.pkt_ok || (data_end && !status.lit_last_ok))
                        fail = 1'b1;
                    else
                    begin
                        cmd.emit   = br1_pkg::EMIT_LIT;
                        cmd.upd    = br1_pkg::UPD_LIT;
                        state_next = status.pkt_one ? br1_pkg::ST_HDR : br1_pkg::ST_LIT;
                    end
                end
            end
            br1_pkg::ST_RUNB:
            begin
                if (item_fire)
                begin
                    if (!status.pkt_ok || (data_end && !status.run_exact))
                        fail = 1'b1;
                    else
                    begin
                        cmd.upd    = br1_pkg::UPD_RUN;
                        state_next = br1_pkg::ST_EMIT;
                    end
                end
            end
            br1_pkg::ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = br1_pkg::EMIT_CHUNK;
                    if (status.chunk_last)
                        state_next = br1_pkg::ST_HDR;
                end
            end
            br1_pkg::ST_DISC:
            begin
                if (item_fire && data_end)
                begin
                    cmd.upd    = br1_pkg::UPD_RESTART;
                    state_next = br1_pkg::ST_HDR;
                end
            end
            default:
            begin
                state_next = br1_pkg::ST_HDR;
            end
        endcase

        // one error transfer, then either restart or drop input until data_end
        if (fail)
        begin
            cmd.emit = br1_pkg::EMIT_ERR;
            if (data_end)
            begin
                cmd.upd    = br1_pkg::UPD_RESTART;
                state_next = br1_pkg::ST_HDR;
            end
            else
            begin
                cmd.upd    = br1_pkg::UPD_CLEAR_PKT;
                state_next = br1_pkg::ST_DISC;
            end
        end

        if (cfg_fire)
            state_next = br1_pkg::ST_HDR;
    end

endmodule

// ===== hw/rtl/br1_dpath.sv =====
module br1_dpath #(
    parameter int MAX_ROW_BYTES = 8192,
    parameter int OUT_LANES     = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_fire,
    input  logic [13:0]         cfg_row_bytes,
    input  logic [7:0]          in_byte,
    input  logic                result_ready,
    input  br1_pkg::dp_cmd_t     cmd,
    output br1_pkg::dp_status_t  status,
    output logic                result_valid,
    output br1_pkg::out_item_t   result
);

    localparam int ROW_CAP = (MAX_ROW_BYTES > 16383) ? 16383 : MAX_ROW_BYTES;
    localparam int LANES   = (OUT_LANES < 1) ? 1 :
                             ((OUT_LANES > br1_pkg::NUM_LANES) ? br1_pkg::NUM_LANES : OUT_LANES);

    logic [13:0]        row_bytes_reg;
    logic [13:0]        row_left_reg;
    logic [7:0]         pkt_left_reg;
    logic [7:0]         run_left_reg;
    logic [7:0]         run_byte_reg;
    logic               run_rend_reg;
    logic               out_valid_reg;
    br1_pkg::out_item_t out_reg;

    logic [13:0] row_len;
    logic [13:0] cfg_row_len;
    logic [7:0]  hdr_len;
    logic [7:0]  chunk;
    logic [13:0] row_after_run;

    assign row_len     = (row_bytes_reg > 14'(ROW_CAP)) ? 14'(ROW_CAP) : row_bytes_reg;
    assign cfg_row_len = (cfg_row_bytes > 14'(ROW_CAP)) ? 14'(ROW_CAP) : cfg_row_bytes;

    // literal header n gives n+1 bytes, run header gives 257-n
    assign hdr_len = in_byte[7] ? 8'(9'd257 - {1'b0, in_byte}) : 8'(in_byte + 8'd1);

    assign chunk         = (run_left_reg > 8'(LANES)) ? 8'(LANES) : run_left_reg;
    assign row_after_run = row_left_reg - {6'b0, pkt_left_reg};

    assign status.is_lit_hdr   = !in_byte[7];
    assign status.is_nop       = (in_byte == br1_pkg::HDR_NOP);
    assign status.hdr_fits     = ({6'b0, hdr_len} <= row_left_reg);
    assign status.row_at_start = (row_left_reg == row_len);
    assign status.pkt_ok       = (pkt_left_reg != 8'd0) && ({6'b0, pkt_left_reg} <= row_left_reg);
    assign status.pkt_one      = (pkt_left_reg == 8'd1);
    assign status.lit_last_ok  = (pkt_left_reg == 8'd1) && (row_left_reg == 14'd1);
    assign status.run_exact    = ({6'b0, pkt_left_reg} == row_left_reg);
    assign status.chunk_last   = (run_left_reg <= 8'(LANES));
    assign status.slot_free    = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= 14'd40;
            row_left_reg  <= (14'd40 > 14'(ROW_CAP)) ? 14'(ROW_CAP) : 14'd40;
            pkt_left_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            row_bytes_reg <= cfg_row_bytes;
            row_left_reg  <= cfg_row_len;
            pkt_left_reg  <= 8'd0;
        end
        else
        begin
            unique case (cmd.upd)
                br1_pkg::UPD_HDR:
                    pkt_left_reg <= hdr_len;
                br1_pkg::UPD_LIT:
                begin
                    pkt_left_reg <= pkt_left_reg - 8'd1;
                    row_left_reg <= (row_left_reg == 14'd1) ? row_len : row_left_reg - 14'd1;
                end
                br1_pkg::UPD_RUN:
                begin
                    pkt_left_reg <= 8'd0;
                    row_left_reg <= (row_after_run == 14'd0) ? row_len : row_after_run;
                end
                br1_pkg::UPD_CLEAR_PKT:
                    pkt_left_reg <= 8'd0;
                br1_pkg::UPD_RESTART:
                begin
                    pkt_left_reg <= 8'd0;
                    row_left_reg <= row_len;
                end
                default:
                begin
                end
            endcase

            if (cmd.emit != br1_pkg::EMIT_NONE)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // run bookkeeping and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.upd == br1_pkg::UPD_RUN)
        begin
            run_byte_reg <= in_byte;
            run_left_reg <= pkt_left_reg;
            run_rend_reg <= (row_after_run == 14'd0);
        end
        else if (cmd.emit == br1_pkg::EMIT_CHUNK)
            run_left_reg <= run_left_reg - chunk;

        unique case (cmd.emit)
            br1_pkg::EMIT_LIT:
            begin
                out_reg            <= '0;
                out_reg.out_byte0  <= in_byte;
                out_reg.byte_count <= 3'd1;
                out_reg.row_end    <= (row_left_reg == 14'd1);
            end
            br1_pkg::EMIT_CHUNK:
            begin
                out_reg.out_byte0  <= (chunk > 8'd0) ? run_byte_reg : 8'd0;
                out_reg.out_byte1  <= (chunk > 8'd1) ? run_byte_reg : 8'd0;
                out_reg.out_byte2  <= (chunk > 8'd2) ? run_byte_reg : 8'd0;
                out_reg.out_byte3  <= (chunk > 8'd3) ? run_byte_reg : 8'd0;
                out_reg.byte_count <= 3'(chunk);
                out_reg.row_end    <= run_rend_reg && status.chunk_last;
                out_reg.error      <= 1'b0;
            end
            br1_pkg::EMIT_ERR:
            begin
                out_reg       <= '0;
                out_reg.error <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/byterun1_row_decoder.sv =====
// ByteRun1 (PackBits) row decoder.
// Input channel (item_valid / item_ready / item): one compressed byte per
// transfer, with data_end flagging the last byte of the stream.
// Result channel (result_valid / result_ready / result): decoded bytes, one
// per transfer for literals and up to OUT_LANES, at most NUM_LANES, per
// transfer for runs, with row_end on the transfer that completes a row and
// error on a single transfer that reports corrupt or truncated data.
// Config channel (cfg_valid / cfg_ready / cfg_row_bytes): row length in
// bytes; a write also restarts the decoder at a row start. Write only while
// idle. cfg_ready is always high.
// Flow: headers and literal bytes are taken back to back while the output
// register is free. After a run byte is taken, the run emitter owns the
// output register and input is held off until the last chunk of the run.
// Results: a literal or error result is registered and offered in the cycle
// after its byte is taken; a run's first chunk is registered from ST_EMIT.
// Reset: row length returns to 40, decoder waits for a header, output empty.
// Stall: a single output register parts the channels; while it is full and
// result_ready is low, input and run emission hold.
module byterun1_row_decoder #(
    parameter int MAX_ROW_BYTES = 8192,
    parameter int OUT_LANES     = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [13:0]        cfg_row_bytes,
    input  logic               item_valid,
    output logic               item_ready,
    input  br1_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output br1_pkg::out_item_t result
);

    br1_pkg::dp_cmd_t    cmd;
    br1_pkg::dp_status_t status;
    logic                cfg_fire;

    // always take config; the contract keeps it to idle periods
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    br1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .data_end   (item.data_end),
        .cfg_fire   (cfg_fire),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    br1_dpath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .OUT_LANES     (OUT_LANES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_fire      (cfg_fire),
        .cfg_row_bytes (cfg_row_bytes),
        .in_byte       (item.in_byte),
        .result_ready  (result_ready),
        .cmd           (cmd),
        .status        (status),
        .result_valid  (result_valid),
        .result        (result)
    );

endmodule
